FILE: rtl/core/hcfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcfd_pkg;

  // Field widths
  localparam int TEMP_W  = 8;
  localparam int CNT_W   = 8;
  localparam int GAIN_W  = 7;
  localparam int DUTY_W  = 7;
  localparam int EXC_W   = TEMP_W + GAIN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Defaults
  localparam int NUM_CELLS_DEF = 6;

  localparam logic signed [TEMP_W-1:0] HOT_RST    = 8'sd30;
  localparam logic signed [TEMP_W-1:0] SAFE_RST   = 8'sd25;
  localparam logic [CNT_W-1:0]         DANGER_RST = 8'd5;
  localparam logic [GAIN_W-1:0]        GAIN_RST   = 7'd10;

  // Duty of 100 means fan off, 0 means fan at full speed
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd0;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DANGER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd3;

  // Configuration seen by every lane
  typedef struct packed {
    logic signed [TEMP_W-1:0] hot;
    logic signed [TEMP_W-1:0] safe;
    logic [CNT_W-1:0]         danger_count;
    logic [GAIN_W-1:0]        gain;
  } cfg_t;

  // What one lane found for its cell
  typedef struct packed {
    logic              top;
    logic              danger;
    logic [DUTY_W-1:0] duty;
    logic              above_safe;
  } lane_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/hcfd_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module hcfd_lane #(
  parameter int NUM_CELLS = hcfd_pkg::NUM_CELLS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    accept,
  input  wire logic                                    clear,
  input  wire hcfd_pkg::cfg_t                          cfg,
  input  wire logic signed [hcfd_pkg::TEMP_W-1:0]      temp,
  input  wire logic [NUM_CELLS*hcfd_pkg::TEMP_W-1:0]   temps_all,
  output hcfd_pkg::lane_res_t                          res
);
  import hcfd_pkg::*;

  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_sat;
  logic                    top;
  logic signed [TEMP_W:0]  diff;
  logic [EXC_W-1:0]        excess;

  // Hottest test: above the hot limit and not below any cell
  always_comb begin
    top = (temp > cfg.hot);
    for (int j = 0; j < NUM_CELLS; j++) begin
      if ($signed(temps_all[j*TEMP_W +: TEMP_W]) > temp) begin
        top = 1'b0;
      end
    end
  end

  // Saturating increment
  assign cnt_sat = (cnt == CNT_MAX) ? CNT_MAX : cnt + CNT_W'(1);

  // Fan excess; only used when temp is above hot, so diff is 1..255
  assign diff   = {temp[TEMP_W-1], temp} - {cfg.hot[TEMP_W-1], cfg.hot};
  assign excess = EXC_W'(diff[TEMP_W-1:0]) * EXC_W'(cfg.gain);

  always_comb begin
    res.top        = top;
    res.danger     = (cnt_sat > cfg.danger_count);
    res.above_safe = (temp > cfg.safe);
    if (res.danger) begin
      res.duty = DUTY_FULL;
    end else if (excess > EXC_W'(DUTY_OFF)) begin
      res.duty = DUTY_FULL;
    end else begin
      res.duty = DUTY_OFF - excess[DUTY_W-1:0];
    end
  end

  // Overheat counter of this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      if (clear) begin
        cnt <= '0;
      end else if (top) begin
        cnt <= cnt_sat;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hcfd_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module hcfd_merge #(
  parameter int NUM_CELLS = hcfd_pkg::NUM_CELLS_DEF,
  localparam int HW    = $clog2(NUM_CELLS + 1),
  localparam int RES_W = 2*hcfd_pkg::DUTY_W + HW + 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire hcfd_pkg::lane_res_t lane_res [NUM_CELLS],
  output logic                     safe,
  output logic [RES_W-1:0]         res_data
);
  import hcfd_pkg::*;

  logic [DUTY_W-1:0] duty_reg;
  logic [DUTY_W-1:0] duty_reg_next;
  logic              alarm_reg;
  logic              alarm_reg_next;
  logic              any_top;
  logic              any_danger;
  logic [HW-1:0]     hot_idx;
  logic              sel_danger;
  logic [DUTY_W-1:0] sel_duty;

  // Last hottest cell wins; any hottest cell in danger latches the alarm
  always_comb begin
    any_top    = 1'b0;
    any_danger = 1'b0;
    hot_idx    = HW'(NUM_CELLS);
    sel_danger = 1'b0;
    sel_duty   = duty_reg;
    safe       = 1'b1;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (lane_res[i].top) begin
        any_top    = 1'b1;
        hot_idx    = HW'(i);
        sel_danger = lane_res[i].danger;
        sel_duty   = lane_res[i].duty;
        any_danger = any_danger | lane_res[i].danger;
      end
      if (lane_res[i].above_safe) begin
        safe = 1'b0;
      end
    end
  end

  // Safe mode overrides the hot handling
  always_comb begin
    if (safe) begin
      duty_reg_next  = DUTY_OFF;
      alarm_reg_next = 1'b0;
    end else begin
      duty_reg_next  = any_top ? sel_duty : duty_reg;
      alarm_reg_next = alarm_reg | any_danger;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_reg  <= '0;
      alarm_reg <= 1'b0;
    end else if (accept) begin
      duty_reg  <= duty_reg_next;
      alarm_reg <= alarm_reg_next;
    end
  end

  // Result: pwm_duty, fan_percent, hot_cell, danger, alarm, safe_mode
  assign res_data = {safe, alarm_reg_next, sel_danger, hot_idx,
                     DUTY_OFF - duty_reg_next, duty_reg_next};

endmodule

`default_nettype wire

FILE: rtl/core/hcfd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module hcfd_out_buf #(
  parameter int W = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              space,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         pop;

  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  // Control: output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/hottest_cell_fan_duty_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Hottest-cell fan duty controller. Each input transaction carries one
// temperature per cell; one lane per cell decides whether that cell is a
// hottest cell above the hot limit and keeps its saturating overheat counter,
// and a merge stage picks the last hottest cell, sets the PWM duty (0 = fan
// full, 100 = fan off), latches the alarm and applies safe mode. One item is
// accepted every clock cycle while the output queue has room and its result
// is registered. The rate is set by the counter, duty and alarm update, which
// completes within the cycle of acceptance so the next item sees it. A
// two-entry output queue lets input continue while a result waits; input
// stalls only when both entries are full. Configuration writes take effect
// at the next edge and should only be made while the block is idle.
module hottest_cell_fan_duty_controller #(
  parameter int NUM_CELLS = hcfd_pkg::NUM_CELLS_DEF,
  localparam int HW      = $clog2(NUM_CELLS + 1),
  localparam int RES_W   = 2*hcfd_pkg::DUTY_W + HW + 3,
  localparam int OUT_W   = ((RES_W + 7) / 8) * 8,
  localparam int IN_W    = NUM_CELLS * hcfd_pkg::TEMP_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // temp_cell0 .. temp_cellN-1, 8 bits each, cell 0 lowest
  input  wire logic [IN_W-1:0]                   s_axis_tdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pwm_duty, fan_percent, hot_cell, danger, alarm, safe_mode, zero pad
  output logic [OUT_W-1:0]                       m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_wr_en,
  input  wire logic [hcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hcfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hcfd_pkg::*;

  cfg_t             cfg;
  logic             accept;
  logic             safe;
  lane_res_t        lane_res [NUM_CELLS];
  logic [RES_W-1:0] res_data;
  logic [RES_W-1:0] out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hot          <= HOT_RST;
      cfg.safe         <= SAFE_RST;
      cfg.danger_count <= DANGER_RST;
      cfg.gain         <= GAIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HOT:    cfg.hot          <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_SAFE:   cfg.safe         <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_DANGER: cfg.danger_count <= cfg_data[CNT_W-1:0];
        CFG_GAIN:   cfg.gain         <= cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  // One lane per cell
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_lane
    hcfd_lane #(
      .NUM_CELLS (NUM_CELLS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .clear     (safe),
      .cfg       (cfg),
      .temp      ($signed(s_axis_tdata[g*TEMP_W +: TEMP_W])),
      .temps_all (s_axis_tdata),
      .res       (lane_res[g])
    );
  end

  hcfd_merge #(
    .NUM_CELLS (NUM_CELLS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .lane_res (lane_res),
    .safe     (safe),
    .res_data (res_data)
  );

  hcfd_out_buf #(
    .W (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_data),
    .space     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = OUT_W'(out_res);

endmodule

`default_nettype wire

FILE: rtl/core/hcfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hcfd_checker #(
  parameter int NUM_CELLS = hcfd_pkg::NUM_CELLS_DEF,
  localparam int HW    = $clog2(NUM_CELLS + 1),
  localparam int RES_W = 2*hcfd_pkg::DUTY_W + HW + 3,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready
);
  import hcfd_pkg::*;

  localparam int HOT_LO = 2*DUTY_W;
  localparam int DNG_B  = HOT_LO + HW;
  localparam int ALM_B  = DNG_B + 1;
  localparam int SAFE_B = DNG_B + 2;

  logic [DUTY_W-1:0] pwm;
  logic [DUTY_W-1:0] fan;
  logic [HW-1:0]     hot;

  assign pwm = m_axis_tdata[DUTY_W-1:0];
  assign fan = m_axis_tdata[2*DUTY_W-1:DUTY_W];
  assign hot = m_axis_tdata[DNG_B-1:HOT_LO];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Duty and fan percent add up to 100
  a_sum: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, pwm} + {1'b0, fan}) == {1'b0, DUTY_OFF})
    else $error("duty and fan percent inconsistent");

  // Safe mode turns the fan off and drops the alarm
  a_safe: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[SAFE_B] |-> pwm == DUTY_OFF && !m_axis_tdata[ALM_B])
    else $error("safe mode result wrong");

  // Danger outside safe mode means full fan and the alarm raised
  a_danger: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[DNG_B] && !m_axis_tdata[SAFE_B]
      |-> pwm == DUTY_FULL && m_axis_tdata[ALM_B])
    else $error("danger without full fan and alarm");

  // No hottest cell, no danger
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && hot == HW'(NUM_CELLS) |-> !m_axis_tdata[DNG_B])
    else $error("danger reported with no hot cell");

endmodule

bind hottest_cell_fan_duty_controller hcfd_checker #(
  .NUM_CELLS (NUM_CELLS)
) u_hcfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

FILE: tb/hottest_cell_fan_duty_controller_tb.sv
`timescale 1ns / 1ps

import hcfd_pkg::*;

localparam int NCELL    = NUM_CELLS_DEF;
localparam int CELL_W   = $clog2(NCELL + 1);
localparam int SAMPLE_W = NCELL * TEMP_W;
localparam int RESULT_W = ((2*DUTY_W + CELL_W + 3 + 7) / 8) * 8;

typedef struct packed {
  logic [DUTY_W-1:0] duty;
  logic [DUTY_W-1:0] fan;
  logic [CELL_W-1:0] hot_idx;
  logic              danger;
  logic              alarm;
  logic              safe_mode;
} fan_result_t;

// Shadow of the controller: thresholds, overheat counters, duty and alarm,
// plus the queue of fan results still to come out of the block
class duty_scoreboard;
  logic signed [TEMP_W-1:0] hot_lim;
  logic signed [TEMP_W-1:0] safe_lim;
  logic [CNT_W-1:0]         danger_lim;
  logic [GAIN_W-1:0]        gain;
  logic [CNT_W-1:0]         overheat [NCELL];
  logic [DUTY_W-1:0]        duty;
  logic                     alarm;
  fan_result_t              fan_results_q[$];
  int errors, accepted, checked, danger_hits, safe_hits, saturated_hits;

  function new();
    hot_lim    = HOT_RST;
    safe_lim   = SAFE_RST;
    danger_lim = DANGER_RST;
    gain       = GAIN_RST;
    foreach (overheat[i]) overheat[i] = '0;
    duty  = '0;
    alarm = 1'b0;
    errors = 0; accepted = 0; checked = 0;
    danger_hits = 0; safe_hits = 0; saturated_hits = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_HOT:    hot_lim    = val;
      CFG_SAFE:   safe_lim   = val;
      CFG_DANGER: danger_lim = val;
      CFG_GAIN:   gain       = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return fan_results_q.size();
  endfunction

  // Work out the fan result of one accepted temperature sample
  function void note_sample(logic [SAMPLE_W-1:0] data);
    logic signed [TEMP_W-1:0] t [NCELL];
    fan_result_t r;
    int excess;
    bit top;
    r = '0;
    r.hot_idx = CELL_W'(NCELL);
    r.safe_mode = 1'b1;
    foreach (t[i]) t[i] = data[i*TEMP_W +: TEMP_W];
    for (int i = 0; i < NCELL; i++) begin
      top = t[i] > hot_lim;
      for (int j = 0; j < NCELL; j++)
        if (t[i] < t[j]) top = 1'b0;
      if (top) begin
        if (overheat[i] != CNT_MAX) overheat[i]++;
        else saturated_hits++;
        r.hot_idx = CELL_W'(i);
        if (overheat[i] > danger_lim) begin
          r.danger = 1'b1;
          duty = DUTY_FULL;
          alarm = 1'b1;
        end else begin
          excess = (int'(t[i]) - int'(hot_lim)) * int'(gain);
          r.danger = 1'b0;
          duty = (excess > int'(DUTY_OFF)) ? DUTY_FULL : DUTY_W'(int'(DUTY_OFF) - excess);
        end
      end
      if (t[i] > safe_lim) r.safe_mode = 1'b0;
    end
    // safe mode overrides whatever the hot handling left behind
    if (r.safe_mode) begin
      foreach (overheat[i]) overheat[i] = '0;
      duty = DUTY_OFF;
      alarm = 1'b0;
    end
    r.duty  = duty;
    r.fan   = DUTY_OFF - duty;
    r.alarm = alarm;
    if (r.danger) danger_hits++;
    if (r.safe_mode) safe_hits++;
    accepted++;
    fan_results_q.push_back(r);
  endfunction

  function void cmp_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Compare one output transaction against the oldest prediction
  function void check_result(logic [RESULT_W-1:0] d);
    fan_result_t e;
    if (fan_results_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got 0x%h", $time, d);
      return;
    end
    e = fan_results_q.pop_front();
    checked++;
    cmp_field("pwm_duty", e.duty, d[0 +: DUTY_W]);
    cmp_field("fan_percent", e.fan, d[DUTY_W +: DUTY_W]);
    cmp_field("hot_cell", e.hot_idx, d[2*DUTY_W +: CELL_W]);
    cmp_field("danger", e.danger, d[2*DUTY_W + CELL_W]);
    cmp_field("alarm", e.alarm, d[2*DUTY_W + CELL_W + 1]);
    cmp_field("safe_mode", e.safe_mode, d[2*DUTY_W + CELL_W + 2]);
  endfunction
endclass

module hottest_cell_fan_duty_controller_tb;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {EP_HOT_RUN, EP_TIE, EP_SAFE, EP_NOISE} episode_t;

  logic                  clk;
  logic                  rst;
  logic [SAMPLE_W-1:0]   s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [RESULT_W-1:0]   m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  duty_scoreboard sb;
  cfg_t cur_cfg;
  int tx_gap_pct;
  int rx_stall_pct;
  int idle_cycles = 0;

  hottest_cell_fan_duty_controller #(
    .NUM_CELLS(NCELL)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return rnd(1, 3);
    if (r < 96) return rnd(4, 12);
    return rnd(20, 60);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] cells(int c0, int c1, int c2, int c3, int c4,
                                                int c5);
    return {TEMP_W'(c5), TEMP_W'(c4), TEMP_W'(c3), TEMP_W'(c2), TEMP_W'(c1), TEMP_W'(c0)};
  endfunction

  // Build one sample of the given episode kind around the current thresholds
  function automatic logic [SAMPLE_W-1:0] make_sample(episode_t kind, int hot_pick);
    logic [SAMPLE_W-1:0] smp;
    int floor_t, peak, v;
    if ($urandom_range(0, 3) == 0) floor_t = int'(cur_cfg.hot) + 1;
    else floor_t = ((cur_cfg.hot > cur_cfg.safe) ? int'(cur_cfg.hot) : int'(cur_cfg.safe)) + 1;
    if (floor_t > 127) floor_t = 127;
    peak = rnd(floor_t, 127);
    for (int i = 0; i < NCELL; i++) begin
      case (kind)
        EP_HOT_RUN: v = (i == hot_pick || $urandom_range(0, 9) == 0) ? peak : rnd(-128, peak);
        EP_TIE:     v = ($urandom_range(0, 1) == 1) ? peak : rnd(-128, peak);
        EP_SAFE:    v = rnd(-128, int'(cur_cfg.safe));
        default:    v = int'($urandom_range(0, 255)) - 128;
      endcase
      smp[i*TEMP_W +: TEMP_W] = TEMP_W'(v);
    end
    return smp;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int h, s;
    h = rnd(-60, 110);
    s = ($urandom_range(0, 3) == 0) ? rnd(-128, 127) : h - rnd(0, 25);
    if (s < -128) s = -128;
    c.hot  = TEMP_W'(h);
    c.safe = TEMP_W'(s);
    c.danger_count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 255))
                                                 : CNT_W'($urandom_range(0, 12));
    c.gain = ($urandom_range(0, 1) == 1) ? GAIN_W'($urandom_range(0, 127))
                                         : GAIN_W'($urandom_range(0, 15));
    return c;
  endfunction

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    int gap;
    @(negedge clk);
    s_axis_tdata  <= smp;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      gap = pick_gap();
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_config(input cfg_t c);
    put_reg(CFG_HOT, c.hot);
    put_reg(CFG_SAFE, c.safe);
    put_reg(CFG_DANGER, c.danger_count);
    put_reg(CFG_GAIN, CFG_DATA_W'(c.gain));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_cfg = c;
  endtask

  // Random episodes: mostly hot runs on one cell, with ties, safe spells and noise
  task automatic run_random(input int budget);
    int sent, len, hot_pick, pick;
    episode_t kind;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 50) ? EP_HOT_RUN : (pick < 65) ? EP_TIE : (pick < 82) ? EP_SAFE : EP_NOISE;
      len = (kind == EP_HOT_RUN && $urandom_range(0, 99) == 0) ? rnd(256, 270) : rnd(1, 10);
      hot_pick = $urandom_range(0, NCELL - 1);
      tx_gap_pct = pick_pct();
      rx_stall_pct = pick_pct();
      for (int k = 0; k < len && sent < budget; k++) begin
        send_sample(make_sample(kind, hot_pick));
        sent++;
      end
    end
  endtask

  // Result side: random back-pressure
  initial begin : rx_side
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < rx_stall_pct) stall = pick_gap();
      end
    end
  end

  // Observe both buses on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Watchdog on cycles with no transaction on either side
  initial begin : watchdog
    @(negedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("hottest_cell_fan_duty_controller_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_HOT;
    cfg_data      = '0;
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    sb = new();
    cur_cfg = '{hot: HOT_RST, safe: SAFE_RST, danger_count: DANGER_RST, gain: GAIN_RST};
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset thresholds: safe, extremes, ties, danger and alarm latch
    send_sample(cells(0, 0, 0, 0, 0, 0));
    send_sample(cells(-128, -128, -128, -128, -128, -128));
    send_sample(cells(127, 127, 127, 127, 127, 127));
    repeat (6) send_sample(cells(127, -128, -128, -128, -128, -128));
    send_sample(cells(20, 20, 20, 35, 20, 20));
    send_sample(cells(20, 20, 20, 20, 31, 20));
    // earlier tied cell in danger, later one sets a nonzero duty
    send_sample(cells(35, -1, -1, -1, -1, 35));
    send_sample(cells(26, 0, 0, 0, 0, 0));
    send_sample(cells(25, 25, 25, 25, 25, 25));
    send_sample(cells(31, 0, 0, 0, 0, 0));

    // safe and hot in the same sample, zero danger count, zero gain
    settle();
    load_config('{hot: -8'sd128, safe: 8'sd127, danger_count: 8'd0, gain: 7'd0});
    send_sample(cells(-127, -128, -128, -128, -128, -128));
    send_sample(cells(127, 127, 127, 127, 127, 127));
    send_sample(cells(-128, -128, -128, -128, -128, -128));
    settle();
    load_config('{hot: 8'sd0, safe: -8'sd128, danger_count: 8'd255, gain: 7'd0});
    send_sample(cells(0, 0, 100, 0, 0, 0));
    send_sample(cells(0, 0, 100, 0, 0, 0));

    // Random phases
    settle();
    load_config('{hot: HOT_RST, safe: SAFE_RST, danger_count: DANGER_RST, gain: GAIN_RST});
    run_random(260);
    settle();
    load_config('{hot: -8'sd128, safe: 8'sd127, danger_count: 8'd0, gain: 7'd0});
    run_random(200);
    settle();
    load_config('{hot: 8'sd127, safe: -8'sd128, danger_count: 8'd255, gain: 7'd127});
    run_random(200);

    // long hot run so that one counter saturates
    settle();
    load_config('{hot: 8'sd0, safe: -8'sd20, danger_count: 8'd254, gain: 7'd127});
    tx_gap_pct = 10;
    rx_stall_pct = 10;
    begin : sat_run
      int hot_pick;
      hot_pick = $urandom_range(0, NCELL - 1);
      repeat (270) send_sample(make_sample(EP_HOT_RUN, hot_pick));
    end
    // hold off the sender until the block has drained
    settle();
    run_random(240);

    repeat (3) begin
      settle();
      c = random_cfg();
      load_config(c);
      run_random(250);
    end

    settle();
    repeat (5) @(negedge clk);
    $display("Covered %0d samples, %0d fan results checked over 9 threshold settings",
             sb.accepted, sb.checked);
    $display("Danger reported %0d times, safe mode %0d times, saturated counter hit %0d times",
             sb.danger_hits, sb.safe_hits, sb.saturated_hits);
    if (sb.errors == 0)
      $display("hottest_cell_fan_duty_controller_tb: PASS");
    else
      $display("hottest_cell_fan_duty_controller_tb: FAIL");
    $finish;
  end

endmodule
